/* rtl/mcc_pkg.sv */
// ----------------------------------------------------------------------------
// mcc_pkg: shared definitions for the monochromatic 6-clique counter
// Widths, register indexes, reset values and the controller/datapath structs.
// ----------------------------------------------------------------------------
package mcc_pkg;

   localparam int DEF_MAX_NODES = 128;
   localparam int CLIQUE_SIZE   = 6;
   localparam int LAST_LEVEL    = CLIQUE_SIZE - 1;
   localparam int LVL_W         = 3;

   localparam int GSIZE_W  = 8;
   localparam int LIMIT_W  = 16;
   localparam int COUNT_W  = 33;
   localparam int IDX_W    = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRAPH_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EARLY_ABANDON = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ABANDON_LIMIT = 2'd2;

   // reset values
   localparam logic [GSIZE_W-1:0] RST_GRAPH_SIZE    = 8'd128;
   localparam logic [LIMIT_W-1:0] RST_ABANDON_LIMIT = 16'd500;

   // word kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic init;    // start a new search
      logic desc;    // open the next level
      logic issue;   // read one edge
      logic eval;    // edge data valid
      logic k_next;  // next edge check of this candidate
      logic adv;     // next candidate on this level
      logic back;    // return to the previous level
      logic count;   // one clique found
      logic post;    // copy the finished count to the result word
   } mcc_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic n_small;     // fewer than six nodes
      logic lvl_zero;
      logic lvl_last;
      logic k_last;
      logic node_over;   // candidate beyond the graph
      logic node_end;    // candidate is the last node
      logic edge_ok;
      logic over_limit;  // early abandon on and next clique would exceed the limit
   } mcc_sts_type;

endpackage

/* rtl/monochromatic_six_clique_counter_unit.sv */
// ----------------------------------------------------------------------------
// monochromatic_six_clique_counter_unit: monochromatic 6-clique counter
// Stores edge colours and counts 6-subsets in which all 15 node pairs share one colour.
// ----------------------------------------------------------------------------
// Load word: no result; while no count is running, a load may follow each cycle.
// Count word: the pruned depth-first walk steps through descents, edge checks
// (an edge read, then its evaluation), returns and candidate advances, then a
// closing step; latency follows the graph. Below six nodes the walk is skipped.
// A result waits in its own register; a later count stalls only at its end.
// Reset (synchronous) clears the controller, configuration, count and result registers;
// the edge store is not cleared and must be loaded before counting.
module monochromatic_six_clique_counter_unit
   import mcc_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [IDX_W-1:0]      req_edge_index,
   input  logic                  req_edge_color,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_W-1:0]    rsp_clique_count,
   output logic                  rsp_abandoned,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   mcc_cmd_type cmd;
   mcc_sts_type sts;
   logic        load_en;

   assign load_en = req_valid && req_ready && (req_kind == KIND_LOAD);

   mcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mcc_datapath #(
      .MaxNodes (MAX_NODES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .load_en      (load_en),
      .edge_index   (req_edge_index),
      .edge_color   (req_edge_color),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .sts          (sts),
      .clique_count (rsp_clique_count),
      .abandoned    (rsp_abandoned)
   );

   // a count word leaves the block busy in the cycle after it is taken
   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_COUNT) |=> !req_ready)
      else $error("ready high right after a count word");

   // no edge read for a candidate past the last node
   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !sts.node_over)
      else $error("edge read beyond graph");

   // cliques are only counted on the deepest level
   a_count_level: assert property (@(posedge clock) disable iff (reset)
      cmd.count |-> (sts.lvl_last && sts.k_last))
      else $error("clique counted off the last level");

   // no search activity while a word may be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.issue || cmd.desc || cmd.adv || cmd.count))
      else $error("search active while ready");

endmodule

/* rtl/mcc_ram.sv */
// ----------------------------------------------------------------------------
// mcc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcc_ram #(
   parameter int Width = 1,
   parameter int Depth = 8128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mcc_ctrl.sv */
// ----------------------------------------------------------------------------
// mcc_ctrl: search sequencer
// Walks the depth-first clique search one edge check at a time and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module mcc_ctrl
   import mcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_kind,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  mcc_sts_type sts,
   output mcc_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DESC   = 3'd1;
   localparam logic [2:0] S_ISSUE  = 3'd2;
   localparam logic [2:0] S_EVAL   = 3'd3;
   localparam logic [2:0] S_ADV    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind == KIND_COUNT)) begin
               cmd.init = 1'b1;
               state_in = sts.n_small ? S_FINISH : S_DESC;
            end
         end
         S_DESC: begin
            cmd.desc = 1'b1;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (sts.node_over) begin
               cmd.back = 1'b1;
               state_in = S_ADV;
            end else begin
               cmd.issue = 1'b1;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (!sts.edge_ok) begin
               state_in = S_ADV;
            end else if (!sts.k_last) begin
               cmd.k_next = 1'b1;
               state_in   = S_ISSUE;
            end else if (sts.lvl_last) begin
               cmd.count = 1'b1;
               state_in  = sts.over_limit ? S_FINISH : S_ADV;
            end else begin
               state_in = S_DESC;
            end
         end
         S_ADV: begin
            if (sts.lvl_zero && sts.node_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.adv  = 1'b1;
               state_in = sts.lvl_zero ? S_DESC : S_ISSUE;
            end
         end
         S_FINISH: begin
            // hand over once the result word is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid: set when a search finishes, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/mcc_datapath.sv */
// ----------------------------------------------------------------------------
// mcc_datapath: edge store, search stack and clique count
// Holds the chosen node and its triangular row base per level, the edge
// colour store and the configuration registers.
// ----------------------------------------------------------------------------
module mcc_datapath
   import mcc_pkg::*;
#(
   parameter int MaxNodes = DEF_MAX_NODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_en,
   input  logic [IDX_W-1:0]      edge_index,
   input  logic                  edge_color,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  mcc_cmd_type           cmd,
   output mcc_sts_type           sts,
   output logic [COUNT_W-1:0]    clique_count,
   output logic                  abandoned
);

   localparam int EdgeDepth = MaxNodes * (MaxNodes - 1) / 2;
   localparam int AW = $clog2(EdgeDepth);
   localparam int BW = AW + 2;
   localparam int NW = $clog2(MaxNodes + 1);

   // configuration
   logic [GSIZE_W-1:0] graph_size_ff;
   logic               early_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         graph_size_ff <= RST_GRAPH_SIZE;
         early_ff      <= 1'b0;
         limit_ff      <= RST_ABANDON_LIMIT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GRAPH_SIZE:    graph_size_ff <= csr_data[GSIZE_W-1:0];
            CSR_EARLY_ABANDON: early_ff      <= csr_data[0];
            CSR_ABANDON_LIMIT: limit_ff      <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // node count in use, saturated to the store size
   logic [NW-1:0] n_eff;
   assign n_eff = (int'(graph_size_ff) > MaxNodes) ? NW'(MaxNodes) : NW'(graph_size_ff);

   // search stack
   logic [NW-1:0]    node_ff [CLIQUE_SIZE];
   logic [BW-1:0]    base_ff [CLIQUE_SIZE];
   logic [LVL_W-1:0] lvl_ff, k_ff;
   logic             color_ff;
   logic [COUNT_W-1:0] count_ff;
   logic             abandoned_ff;

   logic [NW-1:0] cur_node;
   logic [BW-1:0] cur_base, base_step;
   assign cur_node  = node_ff[lvl_ff];
   assign cur_base  = base_ff[lvl_ff];
   // row base of node i+1 is that of node i plus n-i-2
   assign base_step = cur_base + BW'(n_eff) - BW'(cur_node) - BW'(2);

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         node_ff[0] <= '0;
         base_ff[0] <= '1;
         lvl_ff     <= '0;
         k_ff       <= '0;
      end
      if (cmd.desc) begin
         node_ff[lvl_ff + LVL_W'(1)] <= cur_node + NW'(1);
         base_ff[lvl_ff + LVL_W'(1)] <= base_step;
         lvl_ff <= lvl_ff + LVL_W'(1);
         k_ff   <= '0;
      end
      if (cmd.k_next) begin
         k_ff <= k_ff + LVL_W'(1);
      end
      if (cmd.adv) begin
         node_ff[lvl_ff] <= cur_node + NW'(1);
         base_ff[lvl_ff] <= base_step;
         k_ff <= '0;
      end
      if (cmd.back) begin
         lvl_ff <= lvl_ff - LVL_W'(1);
         k_ff   <= '0;
      end
   end

   // edge store
   logic [AW-1:0] rd_addr;
   logic [BW-1:0] rd_sum;
   logic          rd_data;
   logic          wr_en;
   logic          first_edge;

   assign rd_sum  = base_ff[k_ff] + BW'(cur_node);
   assign rd_addr = rd_sum[AW-1:0];
   assign wr_en   = load_en && (int'(edge_index) < EdgeDepth);

   mcc_ram #(
      .Width (1),
      .Depth (EdgeDepth)
   ) u_edges (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(edge_index)),
      .wr_data (edge_color),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // first edge of a subset fixes its colour
   assign first_edge = (lvl_ff == LVL_W'(1)) && (k_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.eval && first_edge) begin
         color_ff <= rd_data;
      end
   end

   // clique count and abandon flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         abandoned_ff <= 1'b0;
      end else if (cmd.init) begin
         count_ff     <= '0;
         abandoned_ff <= 1'b0;
      end else if (cmd.count) begin
         count_ff <= count_ff + COUNT_W'(1);
         if (sts.over_limit) begin
            abandoned_ff <= 1'b1;
         end
      end
   end

   // result word, held while the receiver stalls
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_abandoned_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_count_ff     <= '0;
         rsp_abandoned_ff <= 1'b0;
      end else if (cmd.post) begin
         rsp_count_ff     <= count_ff;
         rsp_abandoned_ff <= abandoned_ff;
      end
   end

   assign clique_count = rsp_count_ff;
   assign abandoned    = rsp_abandoned_ff;

   // status
   always_comb begin
      sts.n_small    = int'(n_eff) < CLIQUE_SIZE;
      sts.lvl_zero   = (lvl_ff == '0);
      sts.lvl_last   = (lvl_ff == LVL_W'(LAST_LEVEL));
      sts.k_last     = (k_ff == lvl_ff - LVL_W'(1));
      sts.node_over  = (cur_node >= n_eff);
      sts.node_end   = (cur_node == n_eff - NW'(1));
      sts.edge_ok    = first_edge || (rd_data == color_ff);
      sts.over_limit = early_ff && (count_ff >= COUNT_W'(limit_ff));
   end

endmodule
